[sv/rpn_pkg.sv]
// shared types and constants for the rpn stack statistics engine
package rpn_pkg;

    // command codes
    localparam logic [2:0] CMD_PUSH  = 3'd0;
    localparam logic [2:0] CMD_POP   = 3'd1;
    localparam logic [2:0] CMD_CLEAR = 3'd2;
    localparam logic [2:0] CMD_DROP  = 3'd3;
    localparam logic [2:0] CMD_PICK  = 3'd4;
    localparam logic [2:0] CMD_SUM   = 3'd5;
    localparam logic [2:0] CMD_AVG   = 3'd6;
    localparam logic [2:0] CMD_STD   = 3'd7;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    // shared unit operations
    localparam logic [1:0] OP_DIV  = 2'd0;
    localparam logic [1:0] OP_SQRT = 2'd1;

    // request to the iterative divide / square root unit
    typedef struct packed {
        logic        start;
        logic [1:0]  op;
        logic [63:0] a;
        logic [63:0] b;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_unit_rsp;

    // saturating signed add
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
            return a[63] ? SMIN : SMAX;
        return r;
    endfunction

    // saturating signed subtract
    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63])
            return a[63] ? SMIN : SMAX;
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

[sv/rpn_ram.sv]
// generic single port ram with registered read
module rpn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read first (a write returns the old contents), registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[sv/rpn_divsqrt.sv]
// iterative unsigned divide and bit-by-bit square root, one bit per cycle
module rpn_divsqrt
    import rpn_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);
    logic         r_busy, n_busy;
    logic [1:0]   r_op, n_op;
    logic [6:0]   r_cnt, n_cnt;
    logic [127:0] r_num, n_num;
    logic [63:0]  r_den, n_den;
    logic [65:0]  r_rem, n_rem;
    logic [63:0]  r_q, n_q;
    logic         r_done, n_done;
    logic [65:0]  w_try;
    logic [65:0]  w_trial;

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        n_q    = r_q;
        n_done = 1'b0;
        w_try  = '0;
        w_trial = '0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_cnt  = 7'd0;
            n_rem  = '0;
            n_q    = '0;
            n_den  = i_req.b;
            // square root takes v*2^32 as a 128-bit word, two bits a step
            n_num  = (i_req.op == OP_SQRT) ? {32'd0, i_req.a, 32'd0} : {i_req.a, 64'd0};
        end else if (r_busy) begin
            // restoring step
            if (r_op == OP_SQRT) begin
                w_try   = {r_rem[63:0], r_num[127:126]};
                w_trial = {r_q, 2'b01};
                n_num   = {r_num[125:0], 2'b00};
                if (w_try >= w_trial) begin
                    n_rem = w_try - w_trial;
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = w_try;
                    n_q   = {r_q[62:0], 1'b0};
                end
            end else begin
                w_try = {r_rem[64:0], r_num[127]};
                n_num = {r_num[126:0], 1'b0};
                if (w_try >= {2'b00, r_den}) begin
                    n_rem = w_try - {2'b00, r_den};
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = w_try;
                    n_q   = {r_q[62:0], 1'b0};
                end
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_q;

    // a result only follows a run
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("divsqrt done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == 7'd63 && !i_req.start) |=> r_done)
        else $error("divsqrt missed done");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) $rose(r_busy) |-> r_cnt == 7'd0)
        else $error("divsqrt bad start count");
endmodule

[sv/rpn_stack_statistics_engine.sv]
// top level: rpn operand stack with sum, average and std sequencer
// o_valid follows each accepted command once its result is ready; sum makes one ram read
// per entry, average adds a divide, std makes a second pass over the entries and runs
// three divides and up to two square roots; input stalls until the result is taken
// reset (synchronous, active low) empties the stack; ram contents are not cleared
module rpn_stack_statistics_engine
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [63:0] i_operand,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_result_value,
    output logic [6:0]  o_depth,
    output logic        o_ok
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD1   = 4'd1;
    localparam logic [3:0] S_PICK  = 4'd2;
    localparam logic [3:0] S_PICK2 = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_DIVW  = 4'd5;
    localparam logic [3:0] S_SQ    = 4'd6;
    localparam logic [3:0] S_VAR   = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_WR    = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_POPW  = 4'd11;
    localparam logic [3:0] S_SQD   = 4'd12;
    localparam logic [3:0] S_SQM   = 4'd13;
    localparam logic [3:0] S_SQA   = 4'd14;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_top, n_top;
    logic [2:0]    r_cmd, n_cmd;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_rdv, n_rdv;
    logic [63:0]   r_acc, n_acc;
    logic [63:0]   r_mean, n_mean;
    logic [63:0]   r_pstd, n_pstd;
    logic [63:0]   r_sstd, n_sstd;
    logic [1:0]    r_phase, n_phase;
    logic [63:0]   r_ma, n_ma;
    logic [63:0]   r_sq, n_sq;
    logic          r_ovalid, n_ovalid;
    logic [63:0]   r_res, n_res;
    logic          r_ok, n_ok;

    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [63:0]   w_wdata;
    logic [63:0]   w_rdata;
    t_unit_req     w_req;
    t_unit_rsp     w_rsp;
    logic [63:0]   w_dev;
    logic [63:0]   w_rmag;
    logic [31:0]   w_mx;
    logic [31:0]   w_my;
    logic [63:0]   w_prod;
    logic [64:0]   w_sqsum;
    logic [64:0]   w_accsum;
    logic          w_acc;

    rpn_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    rpn_divsqrt u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign w_dev   = mag(sat_sub(w_rdata, r_mean));
    assign w_rmag  = mag(w_rdata);

    // one 32x32 multiplier for the square: hi*hi, hi*lo, lo*lo
    assign w_mx     = (r_phase == 2'd2) ? r_ma[31:0] : r_ma[63:32];
    assign w_my     = (r_phase == 2'd0) ? r_ma[63:32] : r_ma[31:0];
    assign w_prod   = {32'd0, w_mx} * {32'd0, w_my};
    assign w_sqsum  = {1'b0, r_sq} + ((r_phase == 2'd1) ? {w_prod, 1'b0}
                                                        : {33'd0, w_prod[63:32]});
    assign w_accsum = {1'b0, r_acc} + {1'b0, r_sq};

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_top    = r_top;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_rdv    = 1'b0;
        n_acc    = r_acc;
        n_mean   = r_mean;
        n_pstd   = r_pstd;
        n_sstd   = r_sstd;
        n_phase  = r_phase;
        n_ma     = r_ma;
        n_sq     = r_sq;
        n_ovalid = r_ovalid && i_stall;
        n_res    = r_res;
        n_ok     = r_ok;
        w_we     = 1'b0;
        w_addr   = r_idx[AW-1:0];
        w_wdata  = i_operand;
        w_req    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_cmd = i_cmd;
                    n_res = '0;
                    n_ok  = 1'b0;
                    unique case (i_cmd)
                        CMD_PUSH: begin
                            if (r_top < CW'(STACK_DEPTH)) begin
                                w_we   = 1'b1;
                                w_addr = r_top[AW-1:0];
                                n_top  = r_top + CW'(1);
                                n_ok   = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        CMD_POP, CMD_PICK: begin
                            if (r_top != '0) begin
                                n_idx   = r_top - CW'(1);
                                n_state = S_RD1;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        CMD_CLEAR: begin
                            n_top   = '0;
                            n_ok    = 1'b1;
                            n_state = S_OUT;
                        end
                        CMD_DROP: begin
                            if (r_top != '0) begin
                                n_top = r_top - CW'(1);
                                n_ok  = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        CMD_SUM, CMD_AVG, CMD_STD: begin
                            if (r_top == '0 || (i_cmd == CMD_STD &&
                                (CW+1)'(r_top) + (CW+1)'(3) > (CW+1)'(STACK_DEPTH))) begin
                                n_state = S_OUT;
                            end else begin
                                n_idx   = r_top;
                                n_acc   = '0;
                                n_state = S_SUM;
                            end
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            // wait for the top entry read
            S_RD1: begin
                n_state = (r_cmd == CMD_POP) ? S_POPW : S_PICK;
            end
            S_POPW: begin
                n_res   = w_rdata;
                n_ok    = 1'b1;
                n_top   = r_top - CW'(1);
                n_state = S_OUT;
            end
            // check the index taken from the top value
            S_PICK: begin
                if (w_rdata[63] ? (w_rmag[63:32] != 32'd0)
                                : ({32'd0, w_rdata[63:32]} >= 64'(r_top))) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = w_rdata[63] ? '0 : CW'(w_rdata[63:32]);
                    n_state = S_PICK2;
                    n_rdv   = 1'b1;
                end
            end
            S_PICK2: begin
                if (r_rdv) begin
                    // read of the picked entry issued this cycle, data next
                    n_state = S_PICK2;
                end else begin
                    w_we    = 1'b1;
                    w_addr  = AW'(r_top - CW'(1));
                    w_wdata = w_rdata;
                    n_res   = w_rdata;
                    n_ok    = 1'b1;
                    n_state = S_OUT;
                end
            end
            // walk from the top down, one read per cycle
            S_SUM: begin
                if (r_idx != '0) begin
                    w_addr = AW'(r_idx - CW'(1));
                    n_idx  = r_idx - CW'(1);
                    n_rdv  = 1'b1;
                end
                if (r_rdv) begin
                    n_acc = sat_add(r_acc, w_rdata);
                end
                if (r_idx == '0 && !r_rdv) begin
                    if (r_cmd == CMD_SUM) begin
                        n_state = S_WR;
                        n_phase = 2'd0;
                    end else begin
                        w_req.start = 1'b1;
                        w_req.op    = OP_DIV;
                        w_req.a     = mag(r_acc);
                        w_req.b     = 64'(r_top);
                        n_state     = S_DIVW;
                    end
                end
            end
            S_DIVW: begin
                if (w_rsp.done) begin
                    n_acc = r_acc[63] ? (64'd0 - w_rsp.res) : w_rsp.res;
                    if (r_cmd == CMD_AVG) begin
                        n_state = S_WR;
                        n_phase = 2'd0;
                    end else begin
                        n_mean  = r_acc[63] ? (64'd0 - w_rsp.res) : w_rsp.res;
                        n_acc   = '0;
                        n_idx   = '0;
                        n_state = S_SQ;
                    end
                end
            end
            // sum of squared deviations: read entry r_idx
            S_SQ: begin
                n_state = S_SQD;
            end
            // take the deviation magnitude
            S_SQD: begin
                n_ma    = w_dev;
                n_phase = 2'd0;
                n_state = S_SQM;
            end
            // square of r_ma in Q32.32 over up to three products, saturated
            S_SQM: begin
                case (r_phase)
                    2'd0: begin
                        if (r_ma[63:48] != 16'd0 || w_prod[31]) begin
                            n_sq    = SMAX;
                            n_state = S_SQA;
                        end else begin
                            n_sq    = {w_prod[31:0], 32'd0};
                            n_phase = 2'd1;
                        end
                    end
                    2'd1: begin
                        if (w_sqsum > {1'b0, SMAX}) begin
                            n_sq    = SMAX;
                            n_state = S_SQA;
                        end else begin
                            n_sq    = w_sqsum[63:0];
                            n_phase = 2'd2;
                        end
                    end
                    2'd2: begin
                        n_sq    = (w_sqsum > {1'b0, SMAX}) ? SMAX : w_sqsum[63:0];
                        n_state = S_SQA;
                    end
                    default: n_state = S_SQA;
                endcase
            end
            // add the square to the saturating sum, then next entry
            S_SQA: begin
                n_acc = (w_accsum > {1'b0, SMAX}) ? SMAX : w_accsum[63:0];
                if (r_idx == r_top - CW'(1)) begin
                    n_phase = 2'd0;
                    n_state = S_VAR;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SQ;
                end
            end
            // variances and roots through the shared unit
            S_VAR: begin
                w_req.start = 1'b1;
                w_req.op    = OP_DIV;
                w_req.a     = r_acc;
                w_req.b     = (r_phase == 2'd0) ? 64'(r_top) : 64'(r_top - CW'(1));
                n_state     = S_SQRT;
                if (r_phase == 2'd1 && r_top == CW'(1)) begin
                    w_req.start = 1'b0;
                    n_sstd  = '0;
                    n_phase = 2'd0;
                    n_state = S_WR;
                end
            end
            S_SQRT: begin
                if (w_rsp.done) begin
                    if (r_rdv) begin
                        if (r_phase == 2'd0) begin
                            n_pstd  = w_rsp.res;
                            n_phase = 2'd1;
                            n_state = S_VAR;
                        end else begin
                            n_sstd  = w_rsp.res;
                            n_phase = 2'd0;
                            n_state = S_WR;
                        end
                    end else begin
                        w_req.start = 1'b1;
                        w_req.op    = OP_SQRT;
                        w_req.a     = w_rsp.res;
                        n_rdv       = 1'b1;
                    end
                end else begin
                    n_rdv = r_rdv;
                end
            end
            // write results back
            S_WR: begin
                w_we = 1'b1;
                n_ok = 1'b1;
                if (r_cmd != CMD_STD) begin
                    w_addr  = '0;
                    w_wdata = r_acc;
                    n_res   = r_acc;
                    n_top   = CW'(1);
                    n_state = S_OUT;
                end else begin
                    w_addr  = AW'(r_top + CW'(r_phase));
                    w_wdata = (r_phase == 2'd0) ? r_mean :
                              (r_phase == 2'd1) ? r_pstd : r_sstd;
                    n_phase = r_phase + 2'd1;
                    if (r_phase == 2'd2) begin
                        n_res   = r_sstd;
                        n_top   = r_top + CW'(3);
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= '0;
            r_ovalid <= 1'b0;
            r_rdv    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_ovalid <= n_ovalid;
            r_rdv    <= n_rdv;
        end
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_acc   <= n_acc;
        r_mean  <= n_mean;
        r_pstd  <= n_pstd;
        r_sstd  <= n_sstd;
        r_phase <= n_phase;
        r_ma    <= n_ma;
        r_sq    <= n_sq;
        r_res   <= n_res;
        r_ok    <= n_ok;
    end

    assign o_valid        = r_ovalid;
    assign o_result_value = r_res;
    assign o_depth        = 7'(r_top);
    assign o_ok           = r_ok;

    // sequencer checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_top <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> r_state == S_IDLE)
        else $error("result shown while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) (o_valid && !o_ok) |-> r_res == '0)
        else $error("failed command with nonzero value");
endmodule

[bench/rpn_stack_statistics_engine_tb.sv]
// testbench for the rpn stack statistics engine: queued requests, predicted results
`timescale 1ns / 100ps

module rpn_stack_statistics_engine_tb
    import rpn_pkg::*;
();

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] operand;
    } t_request;

    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  depth;
        logic        ok;
    } t_answer;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall_out;
    logic        in_stall_out_q = 1'b1;
    logic [2:0]  in_cmd = CMD_PUSH;
    logic [63:0] in_operand = 64'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] out_value;
    logic [6:0]  out_depth;
    logic        out_ok;

    t_request pending_requests[$];
    t_answer  expected_answers[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    bit       calm = 1'b0;
    bit       stimulus_done = 1'b0;

    // shadow copy of the stack
    logic [63:0] shadow_stack[DEPTH];
    int          shadow_count = 0;

    rpn_stack_statistics_engine #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall_out),
        .i_cmd(in_cmd), .i_operand(in_operand),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_result_value(out_value), .o_depth(out_depth), .o_ok(out_ok)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // saturating add and subtract
    function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
        return r;
    endfunction

    function automatic logic [63:0] sub_clamped(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
        return r;
    endfunction

    function automatic logic [63:0] absval(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    function automatic logic [63:0] stack_total();
        logic [63:0] s;
        s = 64'd0;
        for (int i = shadow_count - 1; i >= 0; i--) s = add_clamped(s, shadow_stack[i]);
        return s;
    endfunction

    function automatic logic [63:0] quot_toward_zero(logic [63:0] s, logic [63:0] n);
        logic [63:0] q;
        q = absval(s) / n;
        return s[63] ? (64'd0 - q) : q;
    endfunction

    // q32.32 square of a magnitude, clamped to smax
    function automatic logic [63:0] square_q(logic [63:0] m);
        logic [63:0] a, b, r;
        a = m >> 32;
        b = {32'd0, m[31:0]};
        if (a >= 64'h10000) return SMAX;
        r = (a * a) << 32;
        if (r > SMAX) return SMAX;
        r = r + 64'd2 * a * b;
        if (r > SMAX) return SMAX;
        r = r + ((b * b) >> 32);
        return (r > SMAX) ? SMAX : r;
    endfunction

    // floor of sqrt(v * 2^32), bit by bit
    function automatic logic [63:0] root_q(logic [63:0] v);
        logic [127:0] wide;
        logic [65:0]  rem, trial;
        logic [63:0]  root;
        wide = {v, 64'd0} >> 32;
        rem = 66'd0;
        root = 64'd0;
        for (int i = 63; i >= 0; i--) begin
            rem = (rem << 2) | 66'(wide[2*i +: 2]);
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    // predict one answer and update the shadow stack
    function automatic t_answer predict_answer(t_request rq);
        t_answer     ans;
        logic [63:0] t, idx, s, mean, acc, pstd, sstd;
        bit          good;
        ans = '0;
        case (rq.cmd)
            CMD_PUSH: if (shadow_count < DEPTH) begin
                shadow_stack[shadow_count] = rq.operand;
                shadow_count++;
                ans.ok = 1'b1;
            end
            CMD_POP: if (shadow_count > 0) begin
                shadow_count--;
                ans.value = shadow_stack[shadow_count];
                ans.ok = 1'b1;
            end
            CMD_CLEAR: begin
                shadow_count = 0;
                ans.ok = 1'b1;
            end
            CMD_DROP: if (shadow_count > 0) begin
                shadow_count--;
                ans.ok = 1'b1;
            end
            CMD_PICK: if (shadow_count > 0) begin
                t = shadow_stack[shadow_count - 1];
                idx = 64'd0;
                good = 1'b1;
                if (t[63]) good = ((absval(t) >> 32) == 0);
                else idx = t >> 32;
                if (good && idx < shadow_count) begin
                    ans.value = shadow_stack[idx];
                    shadow_stack[shadow_count - 1] = ans.value;
                    ans.ok = 1'b1;
                end
            end
            CMD_SUM, CMD_AVG: if (shadow_count > 0) begin
                s = stack_total();
                if (rq.cmd == CMD_AVG) s = quot_toward_zero(s, shadow_count);
                shadow_stack[0] = s;
                shadow_count = 1;
                ans.value = s;
                ans.ok = 1'b1;
            end
            default: if (shadow_count > 0 && shadow_count + 3 <= DEPTH) begin
                mean = quot_toward_zero(stack_total(), shadow_count);
                acc = 64'd0;
                for (int i = 0; i < shadow_count; i++) begin
                    acc = acc + square_q(absval(sub_clamped(shadow_stack[i], mean)));
                    if (acc > SMAX) acc = SMAX;
                end
                pstd = root_q(acc / shadow_count);
                sstd = (shadow_count > 1) ? root_q(acc / (shadow_count - 1)) : 64'd0;
                shadow_stack[shadow_count] = mean;
                shadow_stack[shadow_count + 1] = pstd;
                shadow_stack[shadow_count + 2] = sstd;
                shadow_count += 3;
                ans.value = sstd;
                ans.ok = 1'b1;
            end
        endcase
        ans.depth = 7'(shadow_count);
        return ans;
    endfunction

    // random q32.32 value, mostly moderate, sometimes extreme
    function automatic logic [63:0] random_value();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return $urandom_range(0, 1) ? SMAX : SMIN;
            2: return {{32{1'b0}}, 32'(0)} | (64'($urandom_range(0, 40)) << 32) | 64'($urandom);
            3: return 64'd0 - ((64'($urandom_range(0, 3)) << 32) | 64'($urandom));
            default: return {{24{$urandom_range(0, 1) == 1}}, 8'($urandom), $urandom};
        endcase
    endfunction

    // stimulus
    initial begin
        t_request rq;
        // directed part: empty cases, full stack, picks, reductions
        pending_requests.push_back('{CMD_POP, 64'd0});
        pending_requests.push_back('{CMD_DROP, 64'd0});
        pending_requests.push_back('{CMD_PICK, 64'd0});
        pending_requests.push_back('{CMD_SUM, 64'd0});
        pending_requests.push_back('{CMD_AVG, 64'd0});
        pending_requests.push_back('{CMD_STD, 64'd0});
        pending_requests.push_back('{CMD_PUSH, 64'h0000_0003_8000_0000});
        pending_requests.push_back('{CMD_STD, 64'd0});
        pending_requests.push_back('{CMD_PUSH, 64'h0000_0000_0000_0000});
        pending_requests.push_back('{CMD_PICK, 64'hFFFF_FFFF_FFFF_FFFF});
        pending_requests.push_back('{CMD_PUSH, 64'hFFFF_FFFF_0000_0000});
        pending_requests.push_back('{CMD_PICK, 64'd0});
        pending_requests.push_back('{CMD_PUSH, 64'h0000_0063_0000_0000});
        pending_requests.push_back('{CMD_PICK, 64'd0});
        pending_requests.push_back('{CMD_PUSH, SMAX});
        pending_requests.push_back('{CMD_PUSH, SMAX});
        pending_requests.push_back('{CMD_SUM, 64'd0});
        pending_requests.push_back('{CMD_PUSH, SMIN});
        pending_requests.push_back('{CMD_PUSH, SMIN});
        pending_requests.push_back('{CMD_AVG, 64'd0});
        pending_requests.push_back('{CMD_PUSH, SMIN});
        pending_requests.push_back('{CMD_STD, 64'd0});
        pending_requests.push_back('{CMD_CLEAR, 64'd0});
        for (int i = 0; i < 66; i++) pending_requests.push_back('{CMD_PUSH, random_value()});
        pending_requests.push_back('{CMD_STD, 64'd0});
        pending_requests.push_back('{CMD_SUM, 64'd0});
        // random part: runs of pushes with random commands between
        for (int i = 0; i < 1800; i++) begin
            rq.operand = random_value();
            if ($urandom_range(0, 99) < 45) rq.cmd = CMD_PUSH;
            else if ($urandom_range(0, 99) < 3) rq.cmd = CMD_CLEAR;
            else rq.cmd = 3'($urandom_range(0, 7));
            pending_requests.push_back(rq);
        end
        repeat (10) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        wait (pending_requests.size() == 0 && !in_valid);
        wait (expected_answers.size() == 0);
        repeat (400) @(posedge clk);
        stimulus_done = 1'b1;
    end

    // idling pattern: a calm stretch without gaps mid run
    always @(negedge clk) begin
        cycle_count <= cycle_count + 1;
        calm <= (cycle_count > 20000 && cycle_count < 60000);
    end

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || !in_stall_out_q) begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 15)) begin
                    in_cmd <= pending_requests[0].cmd;
                    in_operand <= pending_requests[0].operand;
                    in_valid <= 1'b1;
                    void'(pending_requests.pop_front());
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 15);
        end
    end

    // acceptance seen at the last rising edge
    always @(posedge clk) begin
        in_stall_out_q <= in_stall_out;
        if (rst_n && in_valid && !in_stall_out)
            expected_answers.push_back(predict_answer('{in_cmd, in_operand}));
    end

    // monitor
    always @(posedge clk) begin
        t_answer want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_answers.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) $display("unexpected result %h", out_value);
            end else begin
                want = expected_answers.pop_front();
                if (want.value !== out_value || want.depth !== out_depth
                        || want.ok !== out_ok) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: want %h/%0d/%b got %h/%0d/%b", want.value,
                                 want.depth, want.ok, out_value, out_depth, out_ok);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stimulus_done || cycle_count >= CYCLE_LIMIT);
        if (!stimulus_done) begin
            $display("FAIL rpn_stack_statistics_engine");
        end else if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("PASS rpn_stack_statistics_engine");
        end else begin
            $display("FAIL rpn_stack_statistics_engine");
        end
        $finish;
    end

endmodule

[rpn_stack_statistics_engine.f]
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_divsqrt.sv
sv/rpn_stack_statistics_engine.sv
bench/rpn_stack_statistics_engine_tb.sv
